// ----- rtl/core/efg_pkg.sv -----
// efg_pkg: shared types and codes for the event flag group unit
// function codes, wait mode bits, request classes, result kinds and status codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package efg_pkg;

    // incoming function codes
    localparam logic [2:0] FUNC_LOAD   = 3'd0;
    localparam logic [2:0] FUNC_POLL   = 3'd1;
    localparam logic [2:0] FUNC_WAIT   = 3'd2;
    localparam logic [2:0] FUNC_SET    = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;
    localparam logic [2:0] FUNC_DELETE = 3'd5;

    // wait mode bit positions
    localparam int MODE_SET     = 0;
    localparam int MODE_ALL     = 1;
    localparam int MODE_CONSUME = 2;

    // result kinds
    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_WOKEN   = 2'd1;
    localparam logic [1:0] KIND_REMOVED = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNAVAIL = 3'd1;
    localparam logic [2:0] ST_QUEUED  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_DELETED = 3'd4;

    // request class after decode
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_POLL,
        OP_WAIT,
        OP_SET,
        OP_CLEAR,
        OP_DELETE,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  task_id;
        logic [2:0]  mode;
        logic [31:0] mask;
    } t_req;

endpackage

`default_nettype wire

// ----- rtl/core/event_flag_group_unit.sv -----
// event_flag_group_unit: top level of the event flag group
// depends on efg_pkg, efg_front and efg_back
`timescale 1ns / 1ps
`default_nettype none

// Event flag group with an ordered table of up to MAX_WAITERS waiting tasks.
// Each input transfer is one operation: load the flag word, poll, wait,
// notify-set, notify-clear or delete. Every operation ends with exactly one
// reply transfer (kind reply, last high) carrying the flag word and waiter
// count after the operation. Notify first updates the flags, then walks the
// waiters in arrival order; each waiter that matches consumes flags if its
// mode says so and produces a woken transfer ahead of the reply. Delete
// produces one removed transfer per waiter, in order, before its reply.
// Load, poll, wait and unknown codes are answered straight from the idle
// state; notify and delete go through a start step, one step per table entry
// and a reply step, the walk being set by the waiter table, which is read
// one entry per cycle unless a result is due while the output register is held.
// A two-entry request queue sits in front, so up to two further requests
// are taken while the back end is busy; results leave through one output
// register, and the back end pauses only when that register is held.
module event_flag_group_unit
    import efg_pkg::*;
#(
    parameter int MAX_WAITERS = 8,
    parameter int FLAG_BITS   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [7:0]  i_task_id,
    input  wire logic [2:0]  i_wait_mode,
    input  wire logic [31:0] i_flag_mask,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_task_id_out,
    output logic [2:0]       o_status,
    output logic [31:0]      o_result_flags,
    output logic [31:0]      o_current_flags,
    output logic [3:0]       o_waiter_count,
    output logic             o_last
);

    // decoded request handed from the queue to the sequencer
    t_req req;
    logic req_valid;
    logic req_pop;

    // front end: classifies each transfer and buffers it
    efg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_task_id   (i_task_id),
        .i_wait_mode (i_wait_mode),
        .i_flag_mask (i_flag_mask),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    // back end: owns the flag word and waiter table, drives the results
    efg_back #(
        .MAX_WAITERS (MAX_WAITERS),
        .FLAG_BITS   (FLAG_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_valid),
        .i_req           (req),
        .o_req_pop       (req_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_task_id_out   (o_task_id_out),
        .o_status        (o_status),
        .o_result_flags  (o_result_flags),
        .o_current_flags (o_current_flags),
        .o_waiter_count  (o_waiter_count),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/core/efg_front.sv -----
// efg_front: request decode and two-entry request queue
// depends on efg_pkg
`timescale 1ns / 1ps
`default_nettype none

module efg_front
    import efg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [7:0]  i_task_id,
    input  wire logic [2:0]  i_wait_mode,
    input  wire logic [31:0] i_flag_mask,
    output logic             o_req_valid,
    output t_req             o_req,
    input  wire logic        i_req_pop
);

    t_req       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    t_req       dec;

    // classify the function code
    always_comb begin
        dec.task_id = i_task_id;
        dec.mode    = i_wait_mode;
        dec.mask    = i_flag_mask;
        unique case (i_func)
            FUNC_LOAD:   dec.op = OP_LOAD;
            FUNC_POLL:   dec.op = OP_POLL;
            FUNC_WAIT:   dec.op = OP_WAIT;
            FUNC_SET:    dec.op = OP_SET;
            FUNC_CLEAR:  dec.op = OP_CLEAR;
            FUNC_DELETE: dec.op = OP_DELETE;
            default:     dec.op = OP_BAD;
        endcase
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_req_valid = (r_count != 2'd0);
    assign o_req       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_req_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !i_req_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!push && i_req_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/efg_back.sv -----
// efg_back: flag word, waiter table and the sequencer that carries out requests
// depends on efg_pkg; takes requests from efg_front
`timescale 1ns / 1ps
`default_nettype none

module efg_back
    import efg_pkg::*;
#(
    parameter int MAX_WAITERS = 8,
    parameter int FLAG_BITS   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire t_req        i_req,
    output logic             o_req_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_task_id_out,
    output logic [2:0]       o_status,
    output logic [31:0]      o_result_flags,
    output logic [31:0]      o_current_flags,
    output logic [3:0]       o_waiter_count,
    output logic             o_last
);

    localparam int FW = (FLAG_BITS < 32) ? FLAG_BITS : 32;
    localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CW = $clog2(MAX_WAITERS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DEL  = 3'b100
    } t_state;

    typedef struct packed {
        logic [7:0]    task_id;
        logic [2:0]    mode;
        logic [FW-1:0] req;
    } t_entry;

    typedef struct packed {
        logic          hit;
        logic [FW-1:0] found;
        logic [FW-1:0] flags;
    } t_chk;

    function automatic t_chk check(input logic [2:0] mode, input logic [FW-1:0] req,
                                   input logic [FW-1:0] flags);
        t_chk          c;
        logic [FW-1:0] calc;
        calc  = mode[MODE_SET] ? (flags & req) : (~flags & req);
        c.hit = mode[MODE_ALL] ? (calc == req) : (calc != '0);
        c.found = calc;
        c.flags = flags;
        if (c.hit && mode[MODE_CONSUME]) begin
            c.flags = mode[MODE_SET] ? (flags & ~req) : (flags | req);
        end
        return c;
    endfunction

    t_entry        mem [MAX_WAITERS];
    t_entry        r_rd;

    t_state        r_state, n_state;
    logic [FW-1:0] r_flags, n_flags;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_keep, n_keep;
    logic [CW-1:0] r_snap, n_snap;
    logic [7:0]    r_task, n_task;

    logic          out_free;
    logic          emit;
    logic [1:0]    e_kind;
    logic [7:0]    e_task;
    logic [2:0]    e_status;
    logic [FW-1:0] e_res;
    logic          e_last;
    logic          we;
    logic [IW-1:0] waddr;
    t_entry        wdata;
    logic [IW-1:0] raddr;
    logic [FW-1:0] req_mask;
    t_chk          chk_req;
    t_chk          chk_ent;

    logic [1:0]     r_kind;
    logic [7:0]     r_otask;
    logic [2:0]     r_status;
    logic [FW-1:0]  r_res;
    logic [FW-1:0]  r_cur;
    logic [CW-1:0]  r_cnt;
    logic           r_last;
    logic           r_out_valid;
    logic [FW+31:0] res_ext;
    logic [FW+31:0] cur_ext;
    logic [CW+3:0]  cnt_ext;

    assign out_free = !r_out_valid || !i_out_stall;
    assign req_mask = i_req.mask[FW-1:0];
    assign chk_req  = check(i_req.mode, req_mask, r_flags);
    assign chk_ent  = check(r_rd.mode, r_rd.req, r_flags);

    always_comb begin
        n_state   = r_state;
        n_flags   = r_flags;
        n_total   = r_total;
        n_idx     = r_idx;
        n_keep    = r_keep;
        n_snap    = r_snap;
        n_task    = r_task;
        o_req_pop = 1'b0;
        emit      = 1'b0;
        e_kind    = KIND_REPLY;
        e_task    = r_task;
        e_status  = ST_OK;
        e_res     = '0;
        e_last    = 1'b1;
        we        = 1'b0;
        waddr     = r_keep[IW-1:0];
        wdata     = r_rd;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && out_free) begin
                    o_req_pop = 1'b1;
                    e_task    = i_req.task_id;
                    n_task    = i_req.task_id;
                    case (i_req.op) inside
                        OP_LOAD: begin
                            n_flags = req_mask;
                            emit    = 1'b1;
                        end
                        OP_POLL: begin
                            n_flags  = chk_req.flags;
                            e_res    = chk_req.found;
                            e_status = chk_req.hit ? ST_OK : ST_UNAVAIL;
                            emit     = 1'b1;
                        end
                        OP_WAIT: begin
                            n_flags = chk_req.flags;
                            e_res   = chk_req.found;
                            emit    = 1'b1;
                            if (chk_req.hit) begin
                                e_status = ST_OK;
                            end else if (r_total >= CW'(MAX_WAITERS)) begin
                                e_status = ST_FULL;
                            end else begin
                                e_status      = ST_QUEUED;
                                we            = 1'b1;
                                waddr         = r_total[IW-1:0];
                                wdata.task_id = i_req.task_id;
                                wdata.mode    = i_req.mode;
                                wdata.req     = req_mask;
                                n_total       = r_total + CW'(1);
                            end
                        end
                        OP_SET, OP_CLEAR: begin
                            n_flags = (i_req.op == OP_SET) ? (r_flags | req_mask)
                                                           : (r_flags & ~req_mask);
                            n_snap  = r_total;
                            n_idx   = '0;
                            n_keep  = '0;
                            n_state = S_WALK;
                        end
                        OP_DELETE: begin
                            n_snap  = r_total;
                            n_idx   = '0;
                            n_state = S_DEL;
                        end
                        default: begin
                            e_status = ST_UNAVAIL;
                            emit     = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_idx == r_snap) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (chk_ent.hit) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_kind  = KIND_WOKEN;
                        e_task  = r_rd.task_id;
                        e_res   = chk_ent.found;
                        e_last  = 1'b0;
                        n_flags = chk_ent.flags;
                        n_total = r_total - CW'(1);
                        n_idx   = r_idx + CW'(1);
                    end
                end else begin
                    // survivor moves down to close the gap
                    we     = 1'b1;
                    n_keep = r_keep + CW'(1);
                    n_idx  = r_idx + CW'(1);
                end
            end
            S_DEL: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_idx == r_snap) begin
                        n_state = S_IDLE;
                    end else begin
                        e_kind   = KIND_REMOVED;
                        e_task   = r_rd.task_id;
                        e_status = ST_DELETED;
                        e_last   = 1'b0;
                        n_total  = r_total - CW'(1);
                        n_idx    = r_idx + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // read the entry for the next step, in range only
    assign raddr = (n_idx < CW'(MAX_WAITERS)) ? n_idx[IW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flags     <= '0;
            r_total     <= '0;
            r_idx       <= '0;
            r_keep      <= '0;
            r_snap      <= '0;
            r_task      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
            r_total <= n_total;
            r_idx   <= n_idx;
            r_keep  <= n_keep;
            r_snap  <= n_snap;
            r_task  <= n_task;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind   <= e_kind;
            r_otask  <= e_task;
            r_status <= e_status;
            r_res    <= e_res;
            r_cur    <= n_flags;
            r_cnt    <= n_total;
            r_last   <= e_last;
        end
    end

    assign res_ext = {32'd0, r_res};
    assign cur_ext = {32'd0, r_cur};
    assign cnt_ext = {4'd0, r_cnt};

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_task_id_out   = r_otask;
    assign o_status        = r_status;
    assign o_result_flags  = res_ext[31:0];
    assign o_current_flags = cur_ext[31:0];
    assign o_waiter_count  = cnt_ext[3:0];
    assign o_last          = r_last;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for the event flag group unit, with a flag group mirror class
// depends on efg_pkg and event_flag_group_unit
// directed operations first, then weighted random traffic with random idling on both sides
`timescale 1ns / 1ps

import efg_pkg::*;

// one result transfer as seen on the output channel
typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  task_id;
    logic [2:0]  status;
    logic [31:0] found;
    logic [31:0] flags;
    logic [3:0]  count;
    logic        last;
} t_outcome;

// one queued waiter
typedef struct packed {
    logic [7:0]  task_id;
    logic [2:0]  mode;
    logic [31:0] req;
} t_waiter;

// mirror of the flag group: own flag word and waiter table, plus the results still owed
class flag_group_mirror;
    localparam int TABLE_DEPTH = 8;

    logic [31:0]   flag_word = '0;
    t_waiter       waiters[$];
    t_outcome      outcomes_due[$];
    int            errors = 0;
    int            compared = 0;
    int            woken = 0;
    int            removed = 0;
    int            refused = 0;

    // match a request against the flag word, consuming on a hit when the mode asks
    function bit flags_match(input logic [2:0] mode, input logic [31:0] req,
                             output logic [31:0] found);
        logic [31:0] calc;
        bit          hit;
        calc = mode[MODE_SET] ? (flag_word & req) : (~flag_word & req);
        hit  = mode[MODE_ALL] ? (calc == req) : (calc != '0);
        if (hit && mode[MODE_CONSUME])
            flag_word = mode[MODE_SET] ? (flag_word & ~req) : (flag_word | req);
        found = calc;
        return hit;
    endfunction

    function void owe(input logic [1:0] kind, input logic [7:0] task_id,
                      input logic [2:0] status, input logic [31:0] found,
                      input int count, input logic last);
        t_outcome o;
        o.kind    = kind;
        o.task_id = task_id;
        o.status  = status;
        o.found   = found;
        o.flags   = flag_word;
        o.count   = 4'(count);
        o.last    = last;
        outcomes_due.push_back(o);
    endfunction

    // an accepted request: update the mirror and queue the results it causes
    function void apply_request(input logic [2:0] func, input logic [7:0] task_id,
                                input logic [2:0] mode, input logic [31:0] mask);
        logic [31:0]   found;
        t_waiter       still_waiting[$];
        t_waiter       w;
        int            left;
        found = '0;
        case (func) inside
            FUNC_LOAD: begin
                flag_word = mask;
                owe(KIND_REPLY, task_id, ST_OK, '0, waiters.size(), 1'b1);
            end
            FUNC_POLL: begin
                if (flags_match(mode, mask, found))
                    owe(KIND_REPLY, task_id, ST_OK, found, waiters.size(), 1'b1);
                else
                    owe(KIND_REPLY, task_id, ST_UNAVAIL, found, waiters.size(), 1'b1);
            end
            FUNC_WAIT: begin
                if (flags_match(mode, mask, found)) begin
                    owe(KIND_REPLY, task_id, ST_OK, found, waiters.size(), 1'b1);
                end else if (waiters.size() >= TABLE_DEPTH) begin
                    refused++;
                    owe(KIND_REPLY, task_id, ST_FULL, found, waiters.size(), 1'b1);
                end else begin
                    w.task_id = task_id;
                    w.mode    = mode;
                    w.req     = mask;
                    waiters.push_back(w);
                    owe(KIND_REPLY, task_id, ST_QUEUED, found, waiters.size(), 1'b1);
                end
            end
            FUNC_SET, FUNC_CLEAR: begin
                if (func == FUNC_SET)
                    flag_word = flag_word | mask;
                else
                    flag_word = flag_word & ~mask;
                left = waiters.size();
                foreach (waiters[i]) begin
                    if (flags_match(waiters[i].mode, waiters[i].req, found)) begin
                        left--;
                        woken++;
                        owe(KIND_WOKEN, waiters[i].task_id, ST_OK, found, left, 1'b0);
                    end else begin
                        still_waiting.push_back(waiters[i]);
                    end
                end
                waiters = still_waiting;
                owe(KIND_REPLY, task_id, ST_OK, '0, waiters.size(), 1'b1);
            end
            FUNC_DELETE: begin
                left = waiters.size();
                foreach (waiters[i]) begin
                    left--;
                    removed++;
                    owe(KIND_REMOVED, waiters[i].task_id, ST_DELETED, '0, left, 1'b0);
                end
                waiters.delete();
                owe(KIND_REPLY, task_id, ST_OK, '0, 0, 1'b1);
            end
            default: begin
                owe(KIND_REPLY, task_id, ST_UNAVAIL, '0, waiters.size(), 1'b1);
            end
        endcase
    endfunction

    function void field_check(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // an accepted result transfer, compared with the oldest one owed
    function void compare_outcome(input t_outcome got);
        t_outcome want;
        if (outcomes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            return;
        end
        want = outcomes_due.pop_front();
        compared++;
        field_check("kind", 32'(want.kind), 32'(got.kind));
        field_check("task_id_out", 32'(want.task_id), 32'(got.task_id));
        field_check("status", 32'(want.status), 32'(got.status));
        field_check("result_flags", want.found, got.found);
        field_check("current_flags", want.flags, got.flags);
        field_check("waiter_count", 32'(want.count), 32'(got.count));
        field_check("last", 32'(want.last), 32'(got.last));
    endfunction
endclass

module tb_top;
    import efg_pkg::*;

    localparam int          CLK_HALF     = 10;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_ITEMS = 460;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          HOLD_CYCLES  = 300;
    // codes the block does not know, answered as unavailable
    localparam logic [2:0]  FUNC_BAD_LO  = 3'd6;
    localparam logic [2:0]  FUNC_BAD_HI  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_func;
    logic [7:0]  i_task_id;
    logic [2:0]  i_wait_mode;
    logic [31:0] i_flag_mask;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_task_id_out;
    logic [2:0]  o_status;
    logic [31:0] o_result_flags;
    logic [31:0] o_current_flags;
    logic [3:0]  o_waiter_count;
    logic        o_last;

    flag_group_mirror mirror;
    int               cycle_count = 0;
    int               requests_sent = 0;
    // sender idles only outside calm stretches
    bit               tx_calm = 1'b0;

    event_flag_group_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_task_id      (i_task_id),
        .i_wait_mode    (i_wait_mode),
        .i_flag_mask    (i_flag_mask),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_task_id_out  (o_task_id_out),
        .o_status       (o_status),
        .o_result_flags (o_result_flags),
        .o_current_flags(o_current_flags),
        .o_waiter_count (o_waiter_count),
        .o_last         (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, mirror.outcomes_due.size());
            $display("FAIL event_flag_group_unit");
            $finish;
        end
    end

    // idle length for either side: mostly none, some short, a few long
    function automatic int idle_length(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic logic [2:0] mode_of(input bit want_set, input bit want_all,
                                           input bit consume);
        logic [2:0] m;
        m = '0;
        m[MODE_SET]     = want_set;
        m[MODE_ALL]     = want_all;
        m[MODE_CONSUME] = consume;
        return m;
    endfunction

    // masks mostly hit a small window of bits so that waits and notifies meet
    function automatic logic [31:0] pick_mask(input int unsigned lsb);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom();
            default: return 32'($urandom_range(1, 15)) << lsb;
        endcase
    endfunction

    // offer one request and hold it until the transfer happens; valid stays high
    // between back-to-back requests so it is never lowered and raised in one step
    task automatic send_request(input logic [2:0] func, input logic [7:0] task_id,
                                input logic [2:0] mode, input logic [31:0] mask);
        int gap;
        gap = idle_length(tx_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_task_id   <= task_id;
        i_wait_mode <= mode;
        i_flag_mask <= mask;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        mirror.apply_request(func, task_id, mode, mask);
        requests_sent++;
    endtask

    // result side: sample at the edge, then choose the stall for the next cycle
    initial begin
        t_outcome     got;
        int           stall_left;
        int           holds_done;
        int           rx_cycle;
        bit           rx_calm;
        stall_left = 0;
        holds_done = 0;
        rx_cycle   = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                got.kind    = o_kind;
                got.task_id = o_task_id_out;
                got.status  = o_status;
                got.found   = o_result_flags;
                got.flags   = o_current_flags;
                got.count   = o_waiter_count;
                got.last    = o_last;
                mirror.compare_outcome(got);
            end
            rx_cycle++;
            // a recurring calm stretch in which no new random stall is started
            rx_calm = (rx_cycle % 250) < 50;
            if (stall_left == 0) begin
                if (holds_done < 2 && mirror.compared >= (holds_done + 1) * 150) begin
                    // long hold-off: the sender keeps offering, so the request queue
                    // fills and the block has to stall its input
                    stall_left = HOLD_CYCLES;
                    holds_done++;
                end else begin
                    stall_left = idle_length(rx_calm);
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int          r;
        int unsigned hot_lsb;
        logic [2:0]  func;
        logic [2:0]  mode;
        logic [31:0] mask;
        mirror      = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_LOAD;
        i_task_id   = '0;
        i_wait_mode = '0;
        i_flag_mask = '0;
        hot_lsb     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: extremes, every operation, the awkward corners
        send_request(FUNC_LOAD, 8'hFF, mode_of(1, 1, 1), 32'hFFFF_FFFF);
        send_request(FUNC_POLL, 8'h00, mode_of(1, 1, 0), 32'hFFFF_FFFF);
        // poll that consumes the low half
        send_request(FUNC_POLL, 8'h5A, mode_of(1, 1, 1), 32'h0000_FFFF);
        // clear-any poll on now cleared bits
        send_request(FUNC_POLL, 8'hA5, mode_of(0, 0, 0), 32'h0000_000F);
        // poll that misses
        send_request(FUNC_POLL, 8'h11, mode_of(1, 1, 0), 32'h0000_00FF);
        // wait satisfied at once, never queued
        send_request(FUNC_WAIT, 8'h22, mode_of(1, 0, 0), 32'h8000_0000);
        // fill the table: set-waiters on clear low bits, clear-waiters on set high bits
        for (int i = 0; i < 8; i++) begin
            if (i % 2 == 0)
                send_request(FUNC_WAIT, 8'(i + 1), mode_of(1, i[1], i[2]), 32'h1 << i);
            else
                send_request(FUNC_WAIT, 8'(i + 1), mode_of(0, i[1], i[2]), 32'h1 << (16 + i));
        end
        // wait that fails with a full table
        send_request(FUNC_WAIT, 8'h09, mode_of(1, 0, 0), 32'h0000_0001);
        // load leaves the waiters alone
        send_request(FUNC_LOAD, 8'h33, '0, 32'hFFFF_0000);
        send_request(FUNC_SET, 8'h44, '0, 32'h0000_0005);
        send_request(FUNC_CLEAR, 8'h55, '0, 32'h00A0_0000);
        // delete the rest of the table
        send_request(FUNC_DELETE, 8'h66, '0, '0);
        send_request(FUNC_BAD_LO, 8'h77, 3'b111, 32'hDEAD_BEEF);
        send_request(FUNC_BAD_HI, 8'h88, '0, '0);
        send_request(FUNC_SET, 8'h99, '0, '0);
        send_request(FUNC_CLEAR, 8'hAA, '0, 32'hFFFF_FFFF);

        // random part: wait-heavy so the table fills and notifies find work
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                hot_lsb = $urandom_range(0, 28);
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            r    = $urandom_range(0, 99);
            mode = 3'($urandom_range(0, 7));
            mask = pick_mask(hot_lsb);
            if (r < 36)
                func = FUNC_WAIT;
            else if (r < 56)
                func = FUNC_SET;
            else if (r < 68)
                func = FUNC_CLEAR;
            else if (r < 82)
                func = FUNC_POLL;
            else if (r < 91)
                func = FUNC_LOAD;
            else if (r < 96)
                func = FUNC_DELETE;
            else
                func = (r < 98) ? FUNC_BAD_LO : FUNC_BAD_HI;
            send_request(func, 8'($urandom_range(0, 255)), mode, mask);
        end
        i_in_valid <= 1'b0;

        // drain, then a quiet stretch to catch anything extra
        while (mirror.outcomes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d results compared", requests_sent, mirror.compared);
        $display("covered %0d wake-ups, %0d removals by delete, %0d full-table refusals",
                 mirror.woken, mirror.removed, mirror.refused);
        if (mirror.errors == 0) begin
            $display("PASS event_flag_group_unit");
        end else begin
            $display("%0d mismatches", mirror.errors);
            $display("FAIL event_flag_group_unit");
        end
        $finish;
    end
endmodule
